// File: rtl/core/arp_request_responder_core_assert.svh
// Assertion macros for the ARP responder core.
`ifndef ARP_REQUEST_RESPONDER_CORE_ASSERT_SVH
`define ARP_REQUEST_RESPONDER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define ARP_ASSERT_IMP(lbl, c, r, a, b) \
    lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) \
        else $error("arp core: implication check failed");

`define ARP_ASSERT_NXT(lbl, c, r, a, b) \
    lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) \
        else $error("arp core: next-cycle check failed");

`else

`define ARP_ASSERT_IMP(lbl, c, r, a, b)

`define ARP_ASSERT_NXT(lbl, c, r, a, b)

`endif

`endif

// File: rtl/core/arp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package arp_pkg;

    localparam int FRAME_LEN = 42;
    localparam int ADDR_W    = $clog2(FRAME_LEN);
    localparam int MAC_W     = 48;
    localparam int IP_W      = 32;
    localparam int CFG_IDX_W = 1;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [3:0]        status_t;

    localparam addr_t FRAME_CNT = addr_t'(FRAME_LEN);
    localparam addr_t LAST_BYTE = addr_t'(FRAME_LEN - 1);
    localparam addr_t LAST_CHK  = addr_t'(21);

    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'b1;

    localparam status_t ST_OK     = 4'd0;
    localparam status_t ST_DEST   = 4'd1;
    localparam status_t ST_ETYPE  = 4'd2;
    localparam status_t ST_HTYPE  = 4'd3;
    localparam status_t ST_PTYPE  = 4'd4;
    localparam status_t ST_HSIZE  = 4'd5;
    localparam status_t ST_PSIZE  = 4'd6;
    localparam status_t ST_OPCODE = 4'd7;
    localparam status_t ST_SHORT  = 4'd8;

    typedef struct packed {
        logic  clear;
        logic  vld;
        addr_t addr;
    } chk_ctl_t;

    typedef struct packed {
        status_t status;
        logic    is_req;
    } chk_res_t;

    function automatic logic [7:0] mac_byte(input logic [MAC_W-1:0] mac,
                                            input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = mac[47:40];
            3'd1:    b = mac[39:32];
            3'd2:    b = mac[31:24];
            3'd3:    b = mac[23:16];
            3'd4:    b = mac[15:8];
            3'd5:    b = mac[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] ip_byte(input logic [IP_W-1:0] ip,
                                           input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = ip[31:24];
            2'd1:    b = ip[23:16];
            2'd2:    b = ip[15:8];
            default: b = ip[7:0];
        endcase
        return b;
    endfunction

    // store address feeding reply byte k (eth source, then sender MAC/IP)
    function automatic addr_t reply_addr(input addr_t k);
        addr_t a;
        if (k < addr_t'(6))
            a = k + addr_t'(6);
        else
            a = k - addr_t'(10);
        return a;
    endfunction

    function automatic logic [7:0] reply_byte(input addr_t k,
                                              input logic [MAC_W-1:0] mac,
                                              input logic [IP_W-1:0] ip,
                                              input logic [7:0] ram);
        logic [7:0] b;
        case (k) inside
            [6'd0:6'd5], [6'd32:6'd41]: b = ram;
            [6'd6:6'd11]:  b = mac_byte(mac, 3'(k - addr_t'(6)));
            [6'd22:6'd27]: b = mac_byte(mac, 3'(k - addr_t'(22)));
            [6'd28:6'd31]: b = ip_byte(ip, 2'(k - addr_t'(28)));
            6'd12, 6'd16:  b = 8'h08;
            6'd13:         b = 8'h06;
            6'd15:         b = 8'h01;
            6'd18:         b = 8'h06;
            6'd19:         b = 8'h04;
            6'd21:         b = 8'h02;
            default:       b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/arp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module arp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 42
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/arp_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module arp_chk (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire arp_pkg::chk_ctl_t        ctl,
    input  wire logic [7:0]               rd_data,
    input  wire logic [arp_pkg::MAC_W-1:0] own_mac,
    output arp_pkg::chk_res_t             res
);
    import arp_pkg::*;

    logic    bcast_reg, bcast_next;
    logic    mine_reg, mine_next;
    status_t status_reg;
    logic    req_reg;
    status_t fail;

    always_comb
    begin
        bcast_next = bcast_reg && (rd_data == 8'hFF);
        mine_next  = mine_reg && (rd_data == mac_byte(own_mac, ctl.addr[2:0]));
        fail       = ST_OK;
        case (ctl.addr) inside
            6'd5:         fail = (!bcast_next && !mine_next) ? ST_DEST : ST_OK;
            6'd12:        fail = (rd_data != 8'h08) ? ST_ETYPE : ST_OK;
            6'd13:        fail = (rd_data != 8'h06) ? ST_ETYPE : ST_OK;
            6'd14:        fail = (rd_data != 8'h00) ? ST_HTYPE : ST_OK;
            6'd15:        fail = (rd_data != 8'h01) ? ST_HTYPE : ST_OK;
            6'd16:        fail = (rd_data != 8'h08) ? ST_PTYPE : ST_OK;
            6'd17:        fail = (rd_data != 8'h00) ? ST_PTYPE : ST_OK;
            6'd18:        fail = (rd_data != 8'h06) ? ST_HSIZE : ST_OK;
            6'd19:        fail = (rd_data != 8'h04) ? ST_PSIZE : ST_OK;
            6'd20:        fail = (rd_data != 8'h00) ? ST_OPCODE : ST_OK;
            6'd21:        fail = (rd_data != 8'h01 && rd_data != 8'h02) ? ST_OPCODE : ST_OK;
            default:      fail = ST_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcast_reg  <= 1'b1;
            mine_reg   <= 1'b1;
            status_reg <= ST_OK;
            req_reg    <= 1'b0;
        end
        else if (ctl.clear)
        begin
            bcast_reg  <= 1'b1;
            mine_reg   <= 1'b1;
            status_reg <= ST_OK;
            req_reg    <= 1'b0;
        end
        else if (ctl.vld)
        begin
            if (ctl.addr < addr_t'(6))
            begin
                bcast_reg <= bcast_next;
                mine_reg  <= mine_next;
            end
            if (status_reg == ST_OK && fail != ST_OK)
            begin
                status_reg <= fail;
            end
            if (ctl.addr == LAST_CHK)
            begin
                req_reg <= (rd_data == 8'h01);
            end
        end
    end

    assign res.status = status_reg;
    assign res.is_req = req_reg;

endmodule

`default_nettype wire

// File: rtl/core/arp_request_responder_core.sv
// ARP responder core.
// Input channel (in_valid/in_ready): one received frame byte per item, rx_last
// on the final byte. Bytes are taken at one per cycle while a frame arrives;
// the first 42 go into the frame store, the rest are dropped.
// After the last byte in_ready drops. A frame of 42 bytes or more is checked
// by sweeping store addresses 0..21 through the memory read port in S_CHK
// and deciding in S_DEC; its first item is then loaded from S_TX or S_STAT.
// A shorter frame skips this and goes to S_STAT for its status 8 item.
// Output channel (out_valid/out_ready): a valid ARP request gives 42 items,
// the reply frame with tx_valid set and tx_last on the final byte, at one
// item per cycle while out_ready is high; anything else gives one status item
// with tx_last set. Reply bytes are read back from the store one byte ahead.
// in_ready returns once the frame's final item is loaded into the output
// register, so a new frame can start while that item waits to be taken.
// A stalled receiver holds the output register and pauses the reply.
// Configuration: cfg_we writes own_mac (index 0) or own_ip (index 1).
// Reset clears the byte count, configuration and the output register; the
// frame store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module arp_request_responder_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [7:0]                   rx_byte,
    input  wire logic                         rx_last,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [7:0]                        tx_byte,
    output logic                              tx_valid,
    output logic                              tx_last,
    output logic [3:0]                        status,
    input  wire logic                         cfg_we,
    input  wire logic [arp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [arp_pkg::MAC_W-1:0]    cfg_data
);
    import arp_pkg::*;

    `include "arp_request_responder_core_assert.svh"

    typedef enum logic [2:0] {
        S_RX,
        S_CHK,
        S_DEC,
        S_TX,
        S_STAT
    } state_t;

    state_t             state_reg;
    addr_t              cnt_reg;
    addr_t              byte_cnt_reg;
    addr_t              eval_addr_reg;
    logic               eval_vld_reg;
    status_t            stat_reg;
    logic [MAC_W-1:0]   own_mac_reg;
    logic [IP_W-1:0]    own_ip_reg;

    logic               out_valid_reg;
    logic [7:0]         tx_byte_reg;
    logic               tx_valid_reg;
    logic               tx_last_reg;
    status_t            status_reg;

    logic               rx_acc;
    logic               load;
    logic               ram_we;
    logic               ram_re;
    addr_t              ram_raddr;
    logic [7:0]         ram_rdata;
    chk_ctl_t           chk_ctl;
    chk_res_t           chk_res;

    assign in_ready = (state_reg == S_RX);
    assign rx_acc   = in_valid && in_ready;
    assign load     = !out_valid_reg || out_ready;
    assign ram_we   = rx_acc && (byte_cnt_reg < FRAME_CNT);

    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = cnt_reg;
        case (state_reg)
            S_CHK:
            begin
                ram_re    = (cnt_reg <= LAST_CHK);
                ram_raddr = cnt_reg;
            end
            S_DEC:
            begin
                ram_re    = 1'b1;
                ram_raddr = reply_addr('0);
            end
            S_TX:
            begin
                ram_re    = load && (cnt_reg != LAST_BYTE);
                ram_raddr = reply_addr(cnt_reg + addr_t'(1));
            end
            default:
            begin
                ram_re    = 1'b0;
                ram_raddr = cnt_reg;
            end
        endcase
    end

    assign chk_ctl.clear = rx_acc && rx_last && (byte_cnt_reg >= LAST_BYTE);
    assign chk_ctl.vld   = eval_vld_reg;
    assign chk_ctl.addr  = eval_addr_reg;

    arp_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_LEN)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (byte_cnt_reg),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    arp_chk u_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (chk_ctl),
        .rd_data (ram_rdata),
        .own_mac (own_mac_reg),
        .res     (chk_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
            own_ip_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_OWN_MAC)
            begin
                own_mac_reg <= cfg_data;
            end
            else if (cfg_index == REG_OWN_IP)
            begin
                own_ip_reg <= cfg_data[IP_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RX;
            cnt_reg       <= '0;
            byte_cnt_reg  <= '0;
            eval_addr_reg <= '0;
            eval_vld_reg  <= 1'b0;
            stat_reg      <= ST_OK;
            out_valid_reg <= 1'b0;
            tx_byte_reg   <= '0;
            tx_valid_reg  <= 1'b0;
            tx_last_reg   <= 1'b0;
            status_reg    <= ST_OK;
        end
        else
        begin
            if ((state_reg inside {S_TX, S_STAT}) && load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            eval_vld_reg  <= ram_re && (state_reg == S_CHK);
            eval_addr_reg <= cnt_reg;
            case (state_reg)
                S_RX:
                begin
                    if (rx_acc)
                    begin
                        if (rx_last)
                        begin
                            byte_cnt_reg <= '0;
                            cnt_reg      <= '0;
                            if (byte_cnt_reg < LAST_BYTE)
                            begin
                                stat_reg  <= ST_SHORT;
                                state_reg <= S_STAT;
                            end
                            else
                            begin
                                state_reg <= S_CHK;
                            end
                        end
                        else if (byte_cnt_reg < FRAME_CNT)
                        begin
                            byte_cnt_reg <= byte_cnt_reg + addr_t'(1);
                        end
                    end
                end
                S_CHK:
                begin
                    if (cnt_reg <= LAST_CHK)
                    begin
                        cnt_reg <= cnt_reg + addr_t'(1);
                    end
                    if (eval_vld_reg && eval_addr_reg == LAST_CHK)
                    begin
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    cnt_reg  <= '0;
                    stat_reg <= chk_res.status;
                    if (chk_res.status == ST_OK && chk_res.is_req)
                    begin
                        state_reg <= S_TX;
                    end
                    else
                    begin
                        state_reg <= S_STAT;
                    end
                end
                S_TX:
                begin
                    if (load)
                    begin
                        tx_byte_reg   <= reply_byte(cnt_reg, own_mac_reg, own_ip_reg,
                                                    ram_rdata);
                        tx_valid_reg  <= 1'b1;
                        tx_last_reg   <= (cnt_reg == LAST_BYTE);
                        status_reg    <= ST_OK;
                        if (cnt_reg == LAST_BYTE)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_RX;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + addr_t'(1);
                        end
                    end
                end
                S_STAT:
                begin
                    if (load)
                    begin
                        tx_byte_reg   <= '0;
                        tx_valid_reg  <= 1'b0;
                        tx_last_reg   <= 1'b1;
                        status_reg    <= stat_reg;
                        state_reg     <= S_RX;
                    end
                end
                default:
                begin
                    state_reg <= S_RX;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign tx_valid  = tx_valid_reg;
    assign tx_last   = tx_last_reg;
    assign status    = status_reg;

    `ARP_ASSERT_NXT(a_lock_after_last, clk, rst_n, rx_acc && rx_last, !in_ready)
    `ARP_ASSERT_IMP(a_store_locked, clk, rst_n,
                    out_valid_reg && tx_valid_reg && !tx_last_reg, !in_ready)
    `ARP_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, byte_cnt_reg <= FRAME_CNT)
    `ARP_ASSERT_IMP(a_reply_ok, clk, rst_n, out_valid_reg && tx_valid_reg,
                    status_reg == ST_OK)

endmodule

`default_nettype wire
